@@ design/rhsa_pkg.sv @@
// Package for the RGB hue shift / surface adjust block.
// Holds the field widths, hue constants, register indexes and divider lane type.
// Used by rgb_hue_shift_surface_adjust_top.
package rhsa_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned SL_W      = FRAC_BITS + 1;  // sat / light width
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned CH_W      = 8;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [SL_W-1:0]  ONE_Q          = SL_W'(1 << FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_FULL       = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_SIXTH      = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_THIRD      = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_HALF       = 15'd11520;
  localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 15'd15360;

  // Restoring dividers for hue and saturation: 15 quotient bits, one per stage
  localparam int unsigned DIV_STEPS = HUE_W;
  localparam int unsigned DIV_NW    = 25;
  localparam int unsigned DIV_DW    = 10;

  // stage 0 front end, stage 1 divider setup, DIV_STEPS divider stages,
  // then adjust, product, ramp select, multiply, output
  localparam int unsigned NUM_STAGES = DIV_STEPS + 7;

  typedef enum logic [1:0] {
    REG_MODE         = 2'd0,
    REG_HUE_SHIFT    = 2'd1,
    REG_SAT_MAX      = 2'd2,
    REG_LIGHT_TARGET = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } hue_sel_e;

  typedef struct packed {
    logic [DIV_STEPS-1:0] quo;
    logic [DIV_DW-1:0]    rem;
    logic [DIV_STEPS-1:0] nlo;
  } div_lane_t;

endpackage

@@ design/rgb_hue_shift_surface_adjust_top.sv @@
// RGB hue shift / surface adjust: RGB -> HSL -> adjusted HSL -> RGB.
// One word per cycle sustained while the output is not stalled.
// The depth is set by the 15-stage restoring divider (one quotient bit per stage)
// used for hue and saturation; bubbles collapse under output stall.
// Reset (rst_ni low, async) empties the pipeline and sets mode 0, hue_shift 0,
// sat_max 1.0 and light_target 0.5.
module rgb_hue_shift_surface_adjust_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  input  logic [rhsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [38:24] hue_of_input,
  // [51:39] sat_of_input, [64:52] light_of_input, [71:65] zero
  output logic [rhsa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NS = rhsa_pkg::NUM_STAGES;
  localparam int unsigned DS = rhsa_pkg::DIV_STEPS;
  localparam int unsigned SW = rhsa_pkg::SL_W;
  localparam int unsigned HW = rhsa_pkg::HUE_W;
  localparam int unsigned NW = rhsa_pkg::DIV_NW;
  localparam int unsigned DW = rhsa_pkg::DIV_DW;
  localparam int unsigned FB = rhsa_pkg::FRAC_BITS;
  localparam int unsigned ST_ADJ  = DS + 2;
  localparam int unsigned ST_PROD = DS + 3;
  localparam int unsigned ST_RAMP = DS + 4;
  localparam int unsigned ST_MUL  = DS + 5;
  localparam int unsigned ST_OUT  = DS + 6;

  // ---------------- configuration ----------------
  logic                 mode_q;
  logic signed [15:0]   hue_shift_q;
  logic [SW-1:0]        sat_max_q;
  logic [SW-1:0]        light_target_q;
  rhsa_pkg::reg_idx_e   cfg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = rhsa_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b0;
      hue_shift_q    <= '0;
      sat_max_q      <= rhsa_pkg::ONE_Q;
      light_target_q <= SW'(rhsa_pkg::ONE_Q >> 1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        rhsa_pkg::REG_MODE:         mode_q         <= pwdata[0];
        rhsa_pkg::REG_HUE_SHIFT:    hue_shift_q    <= signed'(pwdata[15:0]);
        rhsa_pkg::REG_SAT_MAX:      sat_max_q      <= pwdata[SW-1:0];
        rhsa_pkg::REG_LIGHT_TARGET: light_target_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rhsa_pkg::REG_MODE:         prdata = {31'd0, mode_q};
      rhsa_pkg::REG_HUE_SHIFT:    prdata = {16'd0, hue_shift_q};
      rhsa_pkg::REG_SAT_MAX:      prdata = {(32-SW)'(0), sat_max_q};
      rhsa_pkg::REG_LIGHT_TARGET: prdata = {(32-SW)'(0), light_target_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  // a stage moves when the output drains or this or any later stage holds a bubble
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = m_axis_tready | ~(&vld_q[NS-1:k]);
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------- stage 0: min / max / sextant ----------------
  logic [7:0] in_r, in_g, in_b, mx, mn;
  rhsa_pkg::hue_sel_e sel;
  logic signed [8:0]  hdiff;

  assign in_r = s_axis_tdata[7:0];
  assign in_g = s_axis_tdata[15:8];
  assign in_b = s_axis_tdata[23:16];

  always_comb begin
    mx = in_r;
    if (in_g > mx) mx = in_g;
    if (in_b > mx) mx = in_b;
    mn = in_r;
    if (in_g < mn) mn = in_g;
    if (in_b < mn) mn = in_b;
    if (mx == in_r) begin
      sel   = rhsa_pkg::SEL_RED;
      hdiff = signed'({1'b0, in_g}) - signed'({1'b0, in_b});
    end else if (mx == in_g) begin
      sel   = rhsa_pkg::SEL_GREEN;
      hdiff = signed'({1'b0, in_b}) - signed'({1'b0, in_r});
    end else begin
      sel   = rhsa_pkg::SEL_BLUE;
      hdiff = signed'({1'b0, in_r}) - signed'({1'b0, in_g});
    end
  end

  logic [7:0]         d_q;
  logic [8:0]         sum_q;
  rhsa_pkg::hue_sel_e sel_q;
  logic signed [8:0]  hdiff_q;
  logic               hneg_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d_q     <= mx - mn;
      sum_q   <= {1'b0, mx} + {1'b0, mn};
      sel_q   <= sel;
      hdiff_q <= hdiff;
      hneg_q  <= in_g < in_b;
    end
  end

  // ---------------- stage 1: divider operands ----------------
  // lightness divides by the constant 1020: reciprocal multiply, exact for l_num < 2^22
  localparam logic [22:0] L_RECIP = 23'd4210753;  // ceil(2^32 / 1020)
  localparam int unsigned L_SH    = 32;

  logic signed [NW-1:0] hd_ext, hterm, num_s;
  logic [NW-1:0]        offm, h_num, s_num, l_num;
  logic [NW+22:0]       l_prod;
  logic [7:0]           den;
  logic [DW-1:0]        h_div, s_div;

  always_comb begin
    hd_ext = NW'(hdiff_q);
    hterm  = (hd_ext <<< 12) - (hd_ext <<< 8);  // 3840 * diff
    case (sel_q)
      rhsa_pkg::SEL_RED:   offm = hneg_q ? NW'(d_q) * NW'(rhsa_pkg::HUE_FULL) : '0;
      rhsa_pkg::SEL_GREEN: offm = NW'(d_q) * NW'(rhsa_pkg::HUE_THIRD);
      default:             offm = NW'(d_q) * NW'(rhsa_pkg::HUE_TWO_THIRDS);
    endcase
    num_s = hterm + signed'(offm);
    h_num = (unsigned'(num_s) << 1) + NW'(d_q);
    h_div = (d_q == 8'd0) ? DW'(1) : DW'({d_q, 1'b0});
    den   = (sum_q <= 9'd255) ? sum_q[7:0] : 8'(9'd510 - sum_q);
    s_num = (NW'(d_q) << (FB + 1)) + NW'(den);
    s_div = (den == 8'd0) ? DW'(1) : DW'({den, 1'b0});
    l_num = (NW'(sum_q) << (FB + 1)) + NW'(510);
    l_prod = (NW+23)'(l_num) * (NW+23)'(L_RECIP);
  end

  rhsa_pkg::div_lane_t hl_q [DS+1];
  rhsa_pkg::div_lane_t sl_q [DS+1];
  logic [SW-1:0]       lq_q  [DS+1];
  logic [DW-1:0]       hdv_q [DS+1];
  logic [DW-1:0]       sdv_q [DS+1];
  logic                zf_q  [DS+1];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      hl_q[0]  <= '{quo: '0, rem: h_num[NW-1:DS], nlo: h_num[DS-1:0]};
      sl_q[0]  <= '{quo: '0, rem: s_num[NW-1:DS], nlo: s_num[DS-1:0]};
      lq_q[0]  <= l_prod[L_SH +: SW];
      hdv_q[0] <= h_div;
      sdv_q[0] <= s_div;
      zf_q[0]  <= d_q == 8'd0;
    end
  end

  function automatic rhsa_pkg::div_lane_t div_step(rhsa_pkg::div_lane_t ln,
                                                   logic [DW-1:0] dv);
    logic [DW:0]         t;
    logic                ge;
    rhsa_pkg::div_lane_t o;
    t     = {ln.rem, ln.nlo[DS-1]};
    ge    = t >= {1'b0, dv};
    o.rem = ge ? DW'(t - {1'b0, dv}) : DW'(t);
    o.quo = {ln.quo[DS-2:0], ge};
    o.nlo = {ln.nlo[DS-2:0], 1'b0};
    return o;
  endfunction

  for (genvar j = 0; j < DS; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[j+2]) begin
        hl_q[j+1]  <= div_step(hl_q[j], hdv_q[j]);
        sl_q[j+1]  <= div_step(sl_q[j], sdv_q[j]);
        lq_q[j+1]  <= lq_q[j];
        hdv_q[j+1] <= hdv_q[j];
        sdv_q[j+1] <= sdv_q[j];
        zf_q[j+1]  <= zf_q[j];
      end
    end
  end

  // ---------------- adjust: HSL fixups, mode select ----------------
  logic [HW-1:0]        hue_c, nh_c;
  logic [SW-1:0]        sat_c, light_c, ns_c, nl_c;
  logic signed [16:0]   hs;

  always_comb begin
    if (zf_q[DS]) begin
      hue_c = '0;
      sat_c = '0;
    end else begin
      hue_c = (hl_q[DS].quo >= rhsa_pkg::HUE_FULL) ? hl_q[DS].quo - rhsa_pkg::HUE_FULL
                                                   : hl_q[DS].quo;
      sat_c = (sl_q[DS].quo > DS'(rhsa_pkg::ONE_Q)) ? rhsa_pkg::ONE_Q
                                                    : sl_q[DS].quo[SW-1:0];
    end
    light_c = lq_q[DS];
    hs = signed'({2'b00, hue_c}) + 17'(hue_shift_q);
    if (mode_q == 1'b0) begin
      if (hs >= 17'sd46080)      nh_c = HW'(hs - 17'sd46080);
      else if (hs >= 17'sd23040) nh_c = HW'(hs - 17'sd23040);
      else if (hs >= 17'sd0)     nh_c = HW'(hs);
      else if (hs >= -17'sd23040) nh_c = HW'(hs + 17'sd23040);
      else                       nh_c = HW'(hs + 17'sd46080);
      ns_c = sat_c;
      nl_c = light_c;
    end else begin
      nh_c = hue_c;
      ns_c = (sat_c < sat_max_q) ? sat_c : sat_max_q;
      nl_c = (light_target_q > rhsa_pkg::ONE_Q) ? rhsa_pkg::ONE_Q : light_target_q;
    end
  end

  // forward HSL rides along to the output
  logic [HW-1:0] hue_q [ST_ADJ:ST_OUT];
  logic [SW-1:0] sat_q [ST_ADJ:ST_OUT];
  logic [SW-1:0] lgt_q [ST_ADJ:ST_OUT];

  always_ff @(posedge clk_i) begin
    if (en[ST_ADJ]) begin
      hue_q[ST_ADJ] <= hue_c;
      sat_q[ST_ADJ] <= sat_c;
      lgt_q[ST_ADJ] <= light_c;
    end
    for (int k = ST_ADJ + 1; k <= ST_OUT; k++) begin
      if (en[k]) begin
        hue_q[k] <= hue_q[k-1];
        sat_q[k] <= sat_q[k-1];
        lgt_q[k] <= lgt_q[k-1];
      end
    end
  end

  logic [HW-1:0] nh_q, nh2_q;
  logic [SW-1:0] ns_q, nl_q, ns2_q, nl2_q;
  logic [2*SW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_ADJ]) begin
      nh_q <= nh_c;
      ns_q <= ns_c;
      nl_q <= nl_c;
    end
    if (en[ST_PROD]) begin
      prod_q <= nl_q * ns_q;
      nh2_q  <= nh_q;
      ns2_q  <= ns_q;
      nl2_q  <= nl_q;
    end
  end

  // ---------------- ramp select ----------------
  localparam int unsigned QW = 2 * SW;  // Q(2*FRAC_BITS) values

  function automatic logic [11:0] ramp_f(logic [HW-1:0] t);
    if (t < rhsa_pkg::HUE_SIXTH)           return 12'(t);
    else if (t < rhsa_pkg::HUE_HALF)       return 12'(rhsa_pkg::HUE_SIXTH);
    else if (t < rhsa_pkg::HUE_TWO_THIRDS) return 12'(rhsa_pkg::HUE_TWO_THIRDS - t);
    else                                   return 12'd0;
  endfunction

  logic [QW-1:0] q2, p2;
  logic [HW:0]   tr_w;
  logic [HW-1:0] tr, tb;

  always_comb begin
    if (nl2_q < SW'(rhsa_pkg::ONE_Q >> 1))
      q2 = (QW'(nl2_q) << FB) + prod_q;
    else
      q2 = (QW'(nl2_q) << FB) + (QW'(ns2_q) << FB) - prod_q;
    p2   = (QW'(nl2_q) << (FB + 1)) - q2;
    tr_w = {1'b0, nh2_q} + {1'b0, rhsa_pkg::HUE_THIRD};
    tr   = (tr_w > {1'b0, rhsa_pkg::HUE_FULL}) ? HW'(tr_w - {1'b0, rhsa_pkg::HUE_FULL})
                                               : HW'(tr_w);
    tb   = (nh2_q >= rhsa_pkg::HUE_THIRD) ? nh2_q - rhsa_pkg::HUE_THIRD
                                          : nh2_q + rhsa_pkg::HUE_TWO_THIRDS;
  end

  logic [QW-1:0] p2_q, dq_q;
  logic [11:0]   f_q [3];

  always_ff @(posedge clk_i) begin
    if (en[ST_RAMP]) begin
      p2_q   <= p2;
      dq_q   <= q2 - p2;
      f_q[0] <= ramp_f(tr);
      f_q[1] <= ramp_f(nh2_q);
      f_q[2] <= ramp_f(tb);
    end
  end

  // ---------------- multiply ----------------
  localparam int unsigned MW = QW + 12;

  logic [MW-1:0] base_q;
  logic [MW-1:0] m_q [3];

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      base_q <= (MW'(p2_q) << 12) - (MW'(p2_q) << 8);
      for (int c = 0; c < 3; c++) begin
        m_q[c] <= MW'(dq_q) * MW'(f_q[c]);
      end
    end
  end

  // ---------------- output ----------------
  // channel = round(num * 255 / (3840 << 2F)) = (17*num + 2^(2F+7)) >> (2F+8)
  localparam int unsigned VW = MW + 6;
  localparam int unsigned SH = 2 * FB + 8;

  logic [MW:0]   num_c [3];
  logic [VW-1:0] w_c   [3];
  logic [7:0]    ch_c  [3];
  logic [7:0]    ch_q  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_c[c] = {1'b0, base_q} + {1'b0, m_q[c]};
      w_c[c]   = (VW'(num_c[c]) << 4) + VW'(num_c[c]) + (VW'(1) << (SH - 1));
      ch_c[c]  = (w_c[c][VW-1:SH] > (VW-SH)'(255)) ? 8'd255 : w_c[c][SH+7:SH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      for (int c = 0; c < 3; c++) begin
        ch_q[c] <= ch_c[c];
      end
    end
  end

  assign m_axis_tdata = {7'd0, lgt_q[ST_OUT], sat_q[ST_OUT], hue_q[ST_OUT],
                         ch_q[2], ch_q[1], ch_q[0]};

  // ---------------- assertions ----------------
  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[38:24] < 15'd23040)
    else $error("hue_of_input out of range");

  a_sl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[51:39] <= 13'd4096) && (m_axis_tdata[64:52] <= 13'd4096))
    else $error("saturation or lightness above one");

endmodule

@@ bench/tb_rgb_hue_shift_surface_adjust_top.sv @@
// Testbench for rgb_hue_shift_surface_adjust_top: pixel stream in, HSL and adjusted RGB out.
// A local scoreboard class predicts each output word from the input word and register state.
// Depends on rhsa_pkg and the top module.
module tb_rgb_hue_shift_surface_adjust_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 22;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [12:0] light;
    logic [12:0] sat;
    logic [14:0] hue;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } hsl_word_t;

  class pixel_scoreboard;
    bit          mode;
    int          hue_shift;
    int          sat_max;
    int          light_target;
    hsl_word_t   pending[$];
    int          mismatches;
    int          words_checked;

    function new();
      mode = 0; hue_shift = 0; sat_max = 4096; light_target = 2048;
      mismatches = 0; words_checked = 0;
    endfunction

    function void write_reg(rhsa_pkg::reg_idx_e idx, logic [31:0] val);
      case (idx)
        rhsa_pkg::REG_MODE:         mode = val[0];
        rhsa_pkg::REG_HUE_SHIFT:    hue_shift = int'($signed(val[15:0]));
        rhsa_pkg::REG_SAT_MAX:      sat_max = int'(val[12:0]);
        rhsa_pkg::REG_LIGHT_TARGET: light_target = int'(val[12:0]);
        default: ;
      endcase
    endfunction

    function longint ramp(longint t, longint p2, longint q2);
      longint num;
      longint den;
      longint v;
      den = longint'(3840) << 24;
      if (t < 0) t += 23040;
      if (t > 23040) t -= 23040;
      if (t < 3840) num = p2 * 3840 + (q2 - p2) * t;
      else if (t < 11520) num = q2 * 3840;
      else if (t < 15360) num = p2 * 3840 + (q2 - p2) * (15360 - t);
      else num = p2 * 3840;
      if (num < 0) return 0;
      v = (num * 255 + den / 2) / den;
      return (v > 255) ? 255 : v;
    endfunction

    function void note_pixel(logic [23:0] px);
      longint r, g, b, mx, mn, d, sum, den, num;
      longint hue, sat, light, nh, ns, nl, q2, p2, v;
      hsl_word_t w;
      r = longint'(px[7:0]); g = longint'(px[15:8]); b = longint'(px[23:16]);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn; sum = mx + mn;
      hue = 0; sat = 0;
      light = (sum * 8192 + 510) / 1020;
      if (d != 0) begin
        den = (sum <= 255) ? sum : 510 - sum;
        if (den > 0) sat = (d * 8192 + den) / (2 * den);
        if (sat > 4096) sat = 4096;
        if (mx == r) num = 3840 * (g - b) + ((g < b) ? 23040 * d : 0);
        else if (mx == g) num = 3840 * (b - r) + 7680 * d;
        else num = 3840 * (r - g) + 15360 * d;
        hue = (2 * num + d) / (2 * d);
        if (hue >= 23040) hue -= 23040;
      end
      if (!mode) begin
        nh = (hue + hue_shift) % 23040;
        if (nh < 0) nh += 23040;
        ns = sat; nl = light;
      end else begin
        nh = hue;
        ns = (sat < sat_max) ? sat : sat_max;
        nl = (light_target > 4096) ? 4096 : light_target;
      end
      if (ns == 0) begin
        v = (nl * 255 + 2048) >> 12;
        if (v > 255) v = 255;
        w.red = 8'(v); w.green = 8'(v); w.blue = 8'(v);
      end else begin
        if (nl < 2048) q2 = nl * 4096 + nl * ns;
        else q2 = nl * 4096 + ns * 4096 - nl * ns;
        p2 = 2 * nl * 4096 - q2;
        w.red = 8'(ramp(nh + 7680, p2, q2));
        w.green = 8'(ramp(nh, p2, q2));
        w.blue = 8'(ramp(nh - 7680, p2, q2));
      end
      w.hue = 15'(hue); w.sat = 13'(sat); w.light = 13'(light);
      pending.push_back(w);
    endfunction

    function void check_word(logic [71:0] data);
      hsl_word_t got, exp_w;
      got = data[64:0];
      words_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", data);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w || data[71:65] !== 7'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp rgb %0d %0d %0d hsl %0d %0d %0d, %s %0d %0d %0d hsl %0d %0d %0d",
                   exp_w.red, exp_w.green, exp_w.blue, exp_w.hue, exp_w.sat, exp_w.light,
                   "got rgb", got.red, got.green, got.blue, got.hue, got.sat, got.light);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  pixel_scoreboard pix_sb;
  longint cycle_count;
  bit     hold_off;
  int     pixels_sent;

  rgb_hue_shift_surface_adjust_top u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic apb_write(rhsa_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    pix_sb.write_reg(idx, val);
  endtask

  // valid stays high between back-to-back words; send_pixel drops it only for a gap
  task automatic send_pixel(logic [23:0] px, bit allow_gaps);
    int gap;
    gap = allow_gaps ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    pix_sb.note_pixel(px);
    pixels_sent++;
  endtask

  // random pixel: mostly full range, some greys and saturated colors
  function automatic logic [23:0] rand_pixel();
    int k;
    logic [7:0] c;
    k = $urandom_range(0, 9);
    c = 8'($urandom);
    if (k == 0) return {c, c, c};
    if (k == 1) return {8'($urandom_range(0, 1) * 255), c, 8'($urandom_range(0, 1) * 255)};
    return 24'($urandom);
  endfunction

  task automatic drain_pipe();
    s_axis_tvalid <= 0;
    while (pix_sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 10) hold_off = 1;
      send_pixel(rand_pixel(), 1);
    end
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    m_axis_tready = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end else if ($urandom_range(0, 49) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(10, 50)) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) pix_sb.check_word(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [23:0] directed [$];
    pix_sb = new();
    cycle_count = 0; hold_off = 0; pixels_sent = 0;
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // extremes, greys, each sextant and max-channel tie order
    directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F, 24'h0000FF, 24'h00FF00,
                 24'hFF0000, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h0100FF, 24'h01FF00,
                 24'hFF0001, 24'h80FF80, 24'h010000, 24'hFEFFFF, 24'h55AA33, 24'hAA5533,
                 24'h33AA55};
    foreach (directed[i]) send_pixel(directed[i], 0);
    drain_pipe();

    apb_write(rhsa_pkg::REG_HUE_SHIFT, 32'h0000_5A00);   // +23040
    random_phase(150, 0);
    drain_pipe();
    apb_write(rhsa_pkg::REG_HUE_SHIFT, 32'h0000_A600);   // -23040
    random_phase(150, 1);
    drain_pipe();
    apb_write(rhsa_pkg::REG_HUE_SHIFT, 32'h0000_7FFF);   // beyond one turn
    foreach (directed[i]) send_pixel(directed[i], 1);
    random_phase(100, 0);
    drain_pipe();
    apb_write(rhsa_pkg::REG_HUE_SHIFT, 32'h0000_8000);
    random_phase(100, 1);
    drain_pipe();
    apb_write(rhsa_pkg::REG_HUE_SHIFT, 32'($urandom_range(0, 65535)));
    random_phase(200, 1);
    drain_pipe();

    apb_write(rhsa_pkg::REG_MODE, 32'd1);
    apb_write(rhsa_pkg::REG_SAT_MAX, 32'd0);
    apb_write(rhsa_pkg::REG_LIGHT_TARGET, 32'd4096);
    foreach (directed[i]) send_pixel(directed[i], 0);
    random_phase(100, 1);
    drain_pipe();
    apb_write(rhsa_pkg::REG_SAT_MAX, 32'h1FFF);
    apb_write(rhsa_pkg::REG_LIGHT_TARGET, 32'h1FFF);
    random_phase(150, 1);
    drain_pipe();
    apb_write(rhsa_pkg::REG_LIGHT_TARGET, 32'd0);
    random_phase(100, 1);
    drain_pipe();
    for (int k = 0; k < 4; k++) begin
      apb_write(rhsa_pkg::REG_SAT_MAX, 32'($urandom_range(0, 8191)));
      apb_write(rhsa_pkg::REG_LIGHT_TARGET, 32'($urandom_range(0, 8191)));
      random_phase(100, 1);
      drain_pipe();
    end
    apb_write(rhsa_pkg::REG_MODE, 32'd0);
    apb_write(rhsa_pkg::REG_HUE_SHIFT, 32'd0);
    random_phase(100, 1);
    drain_pipe();

    $display("covered %0d pixels in both modes with hue shifts at +-one turn and beyond,",
             pixels_sent);
    $display("saturation caps and lightness targets at their extremes; %0d words checked",
             pix_sb.words_checked);
    if (pix_sb.mismatches == 0 && pix_sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d words missing", pix_sb.mismatches, pix_sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/rhsa_pkg.sv
design/rgb_hue_shift_surface_adjust_top.sv
bench/tb_rgb_hue_shift_surface_adjust_top.sv
